>>> design/mcec_pkg.sv
// Shared types and constants for the multi-channel edge counter.
// No dependencies; imported by mcec_chan_bank and multi_channel_edge_counter.
package mcec_pkg;

	// Width of the countdown and of the reported count
	localparam int REM_W     = 31;
	localparam int CH_W      = 3;
	localparam int OUT_CNT_W = 32;
	// Widest count the block supports, used for sign extension
	localparam int EXT_W     = 64;

	typedef enum logic [2:0] {
		CMD_EDGE        = 3'd0,
		CMD_ENABLE      = 3'd1,
		CMD_DISABLE     = 3'd2,
		CMD_ARM         = 3'd3,
		CMD_CANCEL      = 3'd4,
		CMD_CLEAR_COUNT = 3'd5,
		CMD_READ_STATUS = 3'd6,
		CMD_RESET_ALL   = 3'd7
	} cmd_t;

	typedef struct packed {
		cmd_t             command;
		logic [CH_W-1:0]  channel;
		logic [REM_W-1:0] target_count;
	} req_t;

	typedef struct packed {
		logic                        status;
		logic signed [OUT_CNT_W-1:0] count_value;
		logic                        overflowed;
		logic                        target_reached;
	} rsp_t;

endpackage

>>> design/mcec_chan_bank.sv
// Per-channel state registers and the single-pass command logic.
// Depends on mcec_pkg for the request/response types and command codes.
module mcec_chan_bank #(
	parameter int NUM_CHANNELS = 6,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  mcec_pkg::req_t req,
	output mcec_pkg::rsp_t rsp
);
	import mcec_pkg::*;

	logic [NUM_CHANNELS-1:0] act_q;
	logic [NUM_CHANNELS-1:0] ovf_q;
	logic [NUM_CHANNELS-1:0] pend_q;
	logic [COUNT_WIDTH-1:0]  cnt_q [NUM_CHANNELS];
	logic [REM_W-1:0]        rem_q [NUM_CHANNELS];

	logic [NUM_CHANNELS-1:0] act_nxt;
	logic [NUM_CHANNELS-1:0] ovf_nxt;
	logic [NUM_CHANNELS-1:0] pend_nxt;
	logic [COUNT_WIDTH-1:0]  cnt_nxt [NUM_CHANNELS];
	logic [REM_W-1:0]        rem_nxt [NUM_CHANNELS];

	logic [NUM_CHANNELS-1:0] sel;
	logic                    in_range;
	logic                    act_sel;
	logic                    ovf_sel;
	logic                    pend_sel;
	logic                    rem_zero_sel;
	logic [COUNT_WIDTH-1:0]  cnt_sel;
	logic signed [EXT_W-1:0] cnt_ext;
	logic                    err;
	logic [COUNT_WIDTH-1:0]  cnt_inc;

	// Decode the addressed channel and pick out its state
	always_comb begin
		in_range     = ({1'b0, req.channel} < (CH_W + 1)'(NUM_CHANNELS));
		act_sel      = 1'b0;
		ovf_sel      = 1'b0;
		pend_sel     = 1'b0;
		rem_zero_sel = 1'b0;
		cnt_sel      = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			sel[i]       = (req.channel == CH_W'(i));
			act_sel      = act_sel | (sel[i] & act_q[i]);
			ovf_sel      = ovf_sel | (sel[i] & ovf_q[i]);
			pend_sel     = pend_sel | (sel[i] & pend_q[i]);
			rem_zero_sel = rem_zero_sel | (sel[i] & (rem_q[i] == '0));
			cnt_sel      = cnt_sel | (cnt_q[i] & {COUNT_WIDTH{sel[i]}});
		end
	end

	// Build the response for this request
	always_comb begin
		if (req.command == CMD_RESET_ALL) begin
			err = 1'b0;
		end else if (!in_range) begin
			err = 1'b1;
		end else if (req.command == CMD_ENABLE) begin
			err = act_sel;
		end else begin
			err = !act_sel || (req.command == CMD_ARM && pend_sel) ||
				(req.command == CMD_CANCEL && !pend_sel);
		end
		cnt_ext            = EXT_W'(signed'(cnt_sel));
		rsp.status         = err;
		rsp.count_value    = '0;
		rsp.overflowed     = 1'b0;
		rsp.target_reached = 1'b0;
		if (!err && req.command == CMD_READ_STATUS) begin
			rsp.count_value = cnt_ext[OUT_CNT_W-1:0];
			rsp.overflowed  = ovf_sel;
		end
		if (!err && req.command == CMD_EDGE) begin
			rsp.target_reached = pend_sel & rem_zero_sel;
		end
	end

	// Next state of every channel
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			act_nxt[i]  = act_q[i];
			ovf_nxt[i]  = ovf_q[i];
			pend_nxt[i] = pend_q[i];
			cnt_nxt[i]  = cnt_q[i];
			rem_nxt[i]  = rem_q[i];
			cnt_inc     = ovf_q[i] ? cnt_q[i] : cnt_q[i] + COUNT_WIDTH'(1);
			if (req.command == CMD_RESET_ALL) begin
				act_nxt[i]  = 1'b0;
				ovf_nxt[i]  = 1'b0;
				pend_nxt[i] = 1'b0;
				cnt_nxt[i]  = '0;
				rem_nxt[i]  = '0;
			end else if (sel[i] && !err) begin
				case (req.command)
					CMD_ENABLE, CMD_DISABLE: begin
						act_nxt[i]  = (req.command == CMD_ENABLE);
						ovf_nxt[i]  = 1'b0;
						pend_nxt[i] = 1'b0;
						cnt_nxt[i]  = '0;
						rem_nxt[i]  = '0;
					end
					CMD_EDGE: begin
						cnt_nxt[i] = cnt_inc;
						ovf_nxt[i] = ovf_q[i] | cnt_inc[COUNT_WIDTH-1];
						if (pend_q[i]) begin
							if (rem_q[i] == '0) begin
								pend_nxt[i] = 1'b0;
							end else begin
								rem_nxt[i] = rem_q[i] - REM_W'(1);
							end
						end
					end
					CMD_ARM: begin
						if (req.target_count != '0) begin
							pend_nxt[i] = 1'b1;
							rem_nxt[i]  = req.target_count - REM_W'(1);
						end
					end
					CMD_CANCEL: begin
						pend_nxt[i] = 1'b0;
						rem_nxt[i]  = '0;
					end
					CMD_CLEAR_COUNT: begin
						cnt_nxt[i] = '0;
					end
					CMD_READ_STATUS: begin
						ovf_nxt[i] = 1'b0;
					end
					default: begin
						act_nxt[i] = act_q[i];
					end
				endcase
			end
		end
	end

	// Commit the new state when the request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= '0;
			ovf_q  <= '0;
			pend_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i] <= '0;
				rem_q[i] <= '0;
			end
		end else if (fire) begin
			act_q  <= act_nxt;
			ovf_q  <= ovf_nxt;
			pend_q <= pend_nxt;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i] <= cnt_nxt[i];
				rem_q[i] <= rem_nxt[i];
			end
		end
	end

`ifndef ASSERT_OFF
	a_pend_needs_act: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~act_q) == '0)
		else $error("countdown pending on a disabled channel");
	a_reset_all: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.command == CMD_RESET_ALL |=> act_q == '0 && pend_q == '0)
		else $error("reset all left a channel enabled or armed");
	a_ovf_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (rsp.overflowed || rsp.count_value != '0) |->
		req.command == CMD_READ_STATUS && !rsp.status)
		else $error("status fields reported outside a read status");
`endif

endmodule

>>> design/multi_channel_edge_counter.sv
// Multi-channel edge counter with compare-match countdown: top level.
// An accepted request is held in the input stage, and its response is then registered in the
// response register; it waits while a stalled response still occupies the response register.
// Throughput: one request per cycle while responses are not stalled; each request is one
// read-modify-write of the addressed channel's registers between the two stages.
// Reset: arst_n clears all channel state and empties both stages asynchronously.
module multi_channel_edge_counter #(
	parameter int NUM_CHANNELS = 6,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mcec_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mcec_pkg::rsp_t rsp_data
);
	import mcec_pkg::*;

	req_t req_s1;
	logic vld_s1;
	rsp_t rsp_q;
	logic rsp_vld_q;
	rsp_t rsp_nxt;
	logic advance;
	logic take;

	// Move the input stage forward when the response register is free
	assign advance   = vld_s1 && !(rsp_vld_q && rsp_stall);
	assign req_stall = vld_s1 && !advance;
	assign take      = req_valid && !req_stall;

	mcec_chan_bank #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_bank (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.req   (req_s1),
		.rsp   (rsp_nxt)
	);

	// Capture the incoming request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take || (vld_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_data;
		end
	end

	// Hold the response until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (advance) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

`ifndef ASSERT_OFF
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(req_s1))
		else $error("input stage dropped or changed a waiting request");
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_vld_q)
		else $error("response register not loaded after advance");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> vld_s1 && rsp_vld_q)
		else $error("request stalled with room in the pipeline");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for multi_channel_edge_counter: directed command checks, then random traffic.
// The bench predicts every response in-line and checks it in order as the response is accepted.
// Depends on mcec_pkg and the design sources under design/.
module tb_top;
	import mcec_pkg::*;

	localparam int NCH         = 6;
	localparam int CW          = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 23;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	// Predicted channel state
	logic [NCH-1:0]   ch_on;
	logic [CW-1:0]    ch_count [NCH];
	logic             ch_ovf   [NCH];
	logic             ch_armed [NCH];
	logic [REM_W-1:0] ch_left  [NCH];

	rsp_t        pending_rsp [$];
	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned n_hits;
	int unsigned n_errs;
	int unsigned n_fail;
	int unsigned cycles;
	bit          quiet;

	multi_channel_edge_counter #(
		.NUM_CHANNELS(NCH),
		.COUNT_WIDTH (CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void clear_chan(input int unsigned c);
		ch_count[c] = '0;
		ch_ovf[c]   = 1'b0;
		ch_armed[c] = 1'b0;
		ch_left[c]  = '0;
	endfunction

	function automatic void clear_all_chans();
		ch_on = '0;
		for (int unsigned i = 0; i < NCH; i++)
			clear_chan(i);
	endfunction

	// Apply one request to the predicted state and return its response
	function automatic rsp_t next_response(input req_t r);
		rsp_t        o;
		int unsigned c;
		o = '0;
		c = 32'(r.channel);
		if (r.command == CMD_RESET_ALL) begin
			clear_all_chans();
			return o;
		end
		if (c >= NCH) begin
			o.status = 1'b1;
			return o;
		end
		if (r.command == CMD_ENABLE) begin
			if (ch_on[c]) begin
				o.status = 1'b1;
			end else begin
				ch_on[c] = 1'b1;
				clear_chan(c);
			end
			return o;
		end
		if (!ch_on[c]) begin
			o.status = 1'b1;
			return o;
		end
		case (r.command)
			CMD_EDGE: begin
				// count holds once overflowed, the countdown keeps ticking
				if (!ch_ovf[c])
					ch_count[c] = ch_count[c] + CW'(1);
				if (ch_count[c][CW-1])
					ch_ovf[c] = 1'b1;
				if (ch_armed[c]) begin
					if (ch_left[c] == '0) begin
						o.target_reached = 1'b1;
						ch_armed[c] = 1'b0;
					end else begin
						ch_left[c] = ch_left[c] - REM_W'(1);
					end
				end
			end
			CMD_DISABLE: begin
				ch_on[c] = 1'b0;
				clear_chan(c);
			end
			CMD_ARM: begin
				if (ch_armed[c]) begin
					o.status = 1'b1;
				end else if (r.target_count != '0) begin
					ch_armed[c] = 1'b1;
					ch_left[c]  = r.target_count - REM_W'(1);
				end
			end
			CMD_CANCEL: begin
				if (!ch_armed[c]) begin
					o.status = 1'b1;
				end else begin
					ch_armed[c] = 1'b0;
					ch_left[c]  = '0;
				end
			end
			CMD_CLEAR_COUNT: ch_count[c] = '0;
			default: begin
				o.count_value = ch_count[c];
				o.overflowed  = ch_ovf[c];
				ch_ovf[c]     = 1'b0;
			end
		endcase
		return o;
	endfunction

	// Send one request, idling first at random; valid stays high afterwards
	task automatic send_request(input cmd_t cmd, input int unsigned chan,
			input logic [REM_W-1:0] tgt);
		req_t        r;
		rsp_t        p;
		int unsigned gap;
		r.command      = cmd;
		r.channel      = chan[CH_W-1:0];
		r.target_count = tgt;
		gap = 0;
		if (!quiet)
			while ($urandom_range(0, 99) < IDLE_PCT)
				gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		p = next_response(r);
		pending_rsp.push_back(p);
		n_sent++;
		n_hits += 32'(p.target_reached);
		n_errs += 32'(p.status);
	endtask

	// Drop valid and hold until every predicted response has been checked
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Check each accepted response against the oldest prediction
	initial begin
		rsp_t want;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("response with no request outstanding");
					n_fail++;
				end else begin
					want = pending_rsp.pop_front();
					n_checked++;
					if (rsp_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_data.status);
						n_fail++;
					end
					if (rsp_data.count_value !== want.count_value) begin
						$error("count_value: expected %0d, got %0d",
							want.count_value, rsp_data.count_value);
						n_fail++;
					end
					if (rsp_data.overflowed !== want.overflowed) begin
						$error("overflowed: expected %0d, got %0d",
							want.overflowed, rsp_data.overflowed);
						n_fail++;
					end
					if (rsp_data.target_reached !== want.target_reached) begin
						$error("target_reached: expected %0d, got %0d",
							want.target_reached, rsp_data.target_reached);
						n_fail++;
					end
				end
			end
			rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Bad channel numbers get an error; reset all ignores the channel
	task automatic test_out_of_range();
		send_request(CMD_ENABLE, 6, '0);
		send_request(CMD_EDGE, 7, '0);
		send_request(CMD_READ_STATUS, 6, '0);
		send_request(CMD_RESET_ALL, 7, '0);
	endtask

	// Commands on a disabled channel fail; double enable fails
	task automatic test_enable_rules();
		send_request(CMD_EDGE, 0, '0);
		send_request(CMD_ENABLE, 0, '0);
		send_request(CMD_ENABLE, 0, '0);
		send_request(CMD_EDGE, 0, '0);
		send_request(CMD_READ_STATUS, 0, '0);
		send_request(CMD_DISABLE, 0, '0);
		send_request(CMD_READ_STATUS, 0, '0);
		send_request(CMD_DISABLE, 5, '0);
	endtask

	// Arm of zero, cancel with nothing armed, rearm while pending, firing, largest target
	task automatic test_countdown();
		send_request(CMD_ENABLE, 5, '0);
		send_request(CMD_ARM, 5, '0);
		send_request(CMD_CANCEL, 5, '0);
		send_request(CMD_ARM, 5, 31'd2);
		send_request(CMD_ARM, 5, 31'd7);
		send_request(CMD_EDGE, 5, '0);
		send_request(CMD_EDGE, 5, '0);
		send_request(CMD_ARM, 5, {REM_W{1'b1}});
		send_request(CMD_CANCEL, 5, '0);
	endtask

	// Clear count, read it back, then wipe everything
	task automatic test_clear_and_reset();
		send_request(CMD_CLEAR_COUNT, 5, '0);
		send_request(CMD_READ_STATUS, 5, '0);
		send_request(CMD_RESET_ALL, 0, '0);
		send_request(CMD_READ_STATUS, 5, '0);
	endtask

	// Random mix weighted toward edges on enabled channels with small countdowns
	task automatic test_random_traffic(input int unsigned n);
		int unsigned      p;
		int unsigned      chan;
		cmd_t             cmd;
		logic [REM_W-1:0] tgt;
		for (int unsigned i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (p < 45)      cmd = CMD_EDGE;
			else if (p < 52) cmd = CMD_ENABLE;
			else if (p < 56) cmd = CMD_DISABLE;
			else if (p < 70) cmd = CMD_ARM;
			else if (p < 74) cmd = CMD_CANCEL;
			else if (p < 79) cmd = CMD_CLEAR_COUNT;
			else if (p < 99) cmd = CMD_READ_STATUS;
			else             cmd = CMD_RESET_ALL;
			if ($urandom_range(0, 99) < 8)
				chan = $urandom_range(NCH, 7);
			else
				chan = $urandom_range(0, NCH - 1);
			// mostly enable an idle channel instead of hitting it with an error
			if (chan < NCH && !ch_on[chan] && cmd != CMD_RESET_ALL &&
					$urandom_range(0, 99) < 70)
				cmd = CMD_ENABLE;
			p = $urandom_range(0, 99);
			if (p < 75)      tgt = REM_W'($urandom_range(1, 6));
			else if (p < 85) tgt = REM_W'($urandom_range(7, 40));
			else if (p < 90) tgt = '0;
			else             tgt = REM_W'($urandom());
			send_request(cmd, chan, tgt);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		quiet     = 1'b0;
		clear_all_chans();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_out_of_range();
		test_enable_rules();
		test_countdown();
		test_clear_and_reset();
		test_random_traffic(500);
		// back-to-back stretch, no idling on either side
		quiet = 1'b1;
		test_random_traffic(200);
		quiet = 1'b0;
		wait_drained();
		test_random_traffic(500);
		wait_drained();

		$display("Sent %0d commands and checked %0d responses in order", n_sent, n_checked);
		$display("Covered %0d countdown completions and %0d error responses", n_hits, n_errs);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
design/mcec_pkg.sv
design/mcec_chan_bank.sv
design/multi_channel_edge_counter.sv
bench/tb_top.sv
